FILE: rtl/pvbp_pkg.sv
`default_nettype none

package pvbp_pkg;

	localparam int CORDIC_STEPS = 28;
	// datapath width of the CORDIC x/y registers (input growth plus gain)
	localparam int CW = 36;
	localparam int MAG_W = 33;
	// 1/K of the CORDIC gain in Q30
	localparam logic [29:0] INV_GAIN = 30'd652032874;
	localparam logic [65:0] GAIN_RND = 66'd536870912;

	localparam logic [0:0] REG_ANALYSIS_HOP = 1'b0;
	localparam logic [0:0] REG_SYNTHESIS_HOP = 1'b1;

	typedef struct packed {
		logic       ch;
		logic [9:0] bin;
		logic       first;
		logic       ok;
	} ctx_t;

	// arctan(2^-i) as a fraction of a full turn, 32 bits
	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sat32(input logic signed [CW-1:0] v);
		logic [31:0] r;
		if (v[CW-1:31] == '0 || v[CW-1:31] == '1) begin
			r = v[31:0];
		end else if (v[CW-1]) begin
			r = 32'h80000000;
		end else begin
			r = 32'h7FFFFFFF;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/pvbp_cordic_vec.sv
`default_nettype none

module pvbp_cordic_vec
	import pvbp_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire ctx_t                in_ctx,
	input  wire logic signed [31:0]  in_re,
	input  wire logic signed [31:0]  in_im,
	output logic                     out_valid,
	output ctx_t                     out_ctx,
	output logic [31:0]              out_ang,
	output logic [MAG_W-1:0]         out_mag
);

	localparam int N = CORDIC_STEPS;

	logic [N:0]             v_s;
	ctx_t                   c_s [0:N];
	logic signed [CW-1:0]   x_s [0:N];
	logic signed [CW-1:0]   y_s [0:N];
	logic [31:0]            a_s [0:N];

	logic                   v_m1;
	ctx_t                   c_m1;
	logic [31:0]            a_m1;
	logic [47:0]            plo_m1;
	logic [46:0]            phi_m1;
	logic [65:0]            sum;

	// fold the left half plane onto the right one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s[0] <= in_ctx;
			if (in_re[31]) begin
				x_s[0] <= -CW'(in_re);
				y_s[0] <= -CW'(in_im);
				a_s[0] <= 32'h80000000;
			end else begin
				x_s[0] <= CW'(in_re);
				y_s[0] <= CW'(in_im);
				a_s[0] <= 32'h0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[i+1] <= c_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] + atan_turn(5'(i));
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					a_s[i+1] <= a_s[i] - atan_turn(5'(i));
				end
			end
		end
	end

	// gain correction, x split in two partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_m1 <= v_s[N];
			out_valid <= v_m1;
		end
	end

	assign sum = (66'(phi_m1) << 18) + 66'(plo_m1) + GAIN_RND;

	always_ff @(posedge clk) begin
		if (en) begin
			c_m1 <= c_s[N];
			a_m1 <= a_s[N];
			plo_m1 <= x_s[N][17:0] * INV_GAIN;
			phi_m1 <= x_s[N][34:18] * INV_GAIN;
			out_ctx <= c_m1;
			out_ang <= a_m1;
			out_mag <= sum[62:30];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/pvbp_cordic_rot.sv
`default_nettype none

module pvbp_cordic_rot
	import pvbp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire ctx_t               in_ctx,
	input  wire logic [MAG_W-1:0]   in_mag,
	input  wire logic [31:0]        in_ang,
	output logic                    out_valid,
	output ctx_t                    out_ctx,
	output logic [31:0]             out_re,
	output logic [31:0]             out_im
);

	localparam int N = CORDIC_STEPS;

	logic                   v_m1, v_m2;
	ctx_t                   c_m1, c_m2;
	logic [31:0]            a_m1, a_m2;
	logic [47:0]            plo_m1;
	logic [44:0]            phi_m1;
	logic [MAG_W-1:0]       x0_m2;
	logic [65:0]            sum;
	logic [31:0]            a_q1;

	logic [N:0]             v_s;
	ctx_t                   c_s [0:N];
	logic signed [CW-1:0]   x_s [0:N];
	logic signed [CW-1:0]   y_s [0:N];
	logic signed [33:0]     z_s [0:N];

	assign sum = (66'(phi_m1) << 18) + 66'(plo_m1) + GAIN_RND;
	assign a_q1 = a_m2 + 32'h40000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_m1 <= in_valid;
			v_m2 <= v_m1;
			v_s[0] <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_m1 <= in_ctx;
			a_m1 <= in_ang;
			plo_m1 <= in_mag[17:0] * INV_GAIN;
			phi_m1 <= in_mag[32:18] * INV_GAIN;
			c_m2 <= c_m1;
			a_m2 <= a_m1;
			x0_m2 <= sum[62:30];
			// left half plane: start from -x and turn the angle by half a turn
			c_s[0] <= c_m2;
			y_s[0] <= '0;
			if (a_q1[31]) begin
				x_s[0] <= -$signed(CW'(x0_m2));
				z_s[0] <= $signed({{2{a_m2[31] ^ 1'b1}}, a_m2 - 32'h80000000});
			end else begin
				x_s[0] <= $signed(CW'(x0_m2));
				z_s[0] <= $signed({{2{a_m2[31]}}, a_m2});
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				c_s[i+1] <= c_s[i];
				if (!z_s[i][33]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed({2'b00, atan_turn(5'(i))});
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed({2'b00, atan_turn(5'(i))});
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctx <= c_s[N];
			out_re <= sat32(x_s[N]);
			out_im <= sat32(y_s[N]);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/phase_vocoder_bin_propagation.sv
`default_nettype none

// channel   dir  width  fields (lsb first)
// s_axis    in   80/2   tdata: bin, real_part, imag_part; tuser: channel, first_frame
// m_axis    out  80/1   tdata: out_bin, out_real, out_imag; tuser: out_channel
// cfg       in   1/11   cfg_index selects analysis_hop (0) or synthesis_hop (1)
//
// One bin per cycle unless m_axis stalls; a bin passes the vectoring CORDIC,
// the phase/divide path (one quotient bit per stage) and the rotating CORDIC.
// Phase RAMs do read-modify-write in fixed stages; back-to-back hits on one
// entry are forwarded. Reset clears valid bits, sets hops to 256/128; RAMs stay unset.
// A stall at m_axis freezes the whole pipeline.

module phase_vocoder_bin_propagation
	import pvbp_pkg::*;
#(
	parameter int FFT_SIZE = 1024,
	parameter int CHANNELS = 2,
	parameter int PHASE_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,   // bin[9:0], real_part[41:10], imag_part[73:42]
	input  wire logic [1:0]  s_axis_tuser,   // channel[0], first_frame[1]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,   // out_bin[9:0], out_real[41:10], out_imag[73:42]
	output logic [0:0]       m_axis_tuser,   // out_channel[0]
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [10:0] cfg_data
);

	localparam int LOG_N = $clog2(FFT_SIZE);
	localparam int BPC = FFT_SIZE / 2 + 1;
	localparam int DEPTH = CHANNELS * BPC;
	localparam int IW = $clog2(DEPTH);
	localparam int PB = PHASE_BITS;
	localparam int PS = 32 - PB;
	localparam int ADV_SH = PB - LOG_N;
	localparam int DW = PB + 12;
	localparam logic [31:0] PH_RND = 32'((64'd1 << PS) >> 1);

	typedef struct packed {
		ctx_t             ctx;
		logic [IW-1:0]    idx;
		logic [PB-1:0]    phase;
		logic [PB-1:0]    adv_s;
		logic [MAG_W-1:0] mag;
	} item_t;

	logic        adv;
	logic [10:0] ha_q, hs_q, ha_eff;
	ctx_t        in_ctx;

	logic             vv;
	ctx_t             vctx;
	logic [31:0]      vang;
	logic [MAG_W-1:0] vmag;
	logic [31:0]      ang_rnd;

	logic [PB-1:0] prev_mem [0:DEPTH-1];
	logic [PB-1:0] acc_mem [0:DEPTH-1];

	logic v_s1, v_s2, v_s3, v_s4, v_s6, v_s7;
	item_t it_s1, it_s2, it_s3, it_s4, it_s6, it_s7;
	logic [20:0] prod_a_s1, prod_s_s1;
	logic [PB-1:0] prev_s2, adv_a_s2, d_s3;
	logic signed [DW-1:0] num_s4;
	logic [DW-1:0] num_abs;

	logic [DW:0]   div_v;
	item_t         div_it [0:DW];
	logic [DW-1:0] div_work [0:DW];
	logic [10:0]   div_rem [0:DW];
	logic [DW:0]   div_neg;

	logic [PB-1:0] q, inc_s6, inc_s7, rd_s7, fwdv_s7, acc_new;
	logic fwd_s7;

	logic             rot_v;
	ctx_t             rot_ctx;
	logic [MAG_W-1:0] rot_mag;
	logic [31:0]      out_re, out_im;
	ctx_t             m_axis_ctx;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ha_q <= 11'd256;
			hs_q <= 11'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANALYSIS_HOP:  ha_q <= cfg_data;
				REG_SYNTHESIS_HOP: hs_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a zero analysis hop behaves as one
	assign ha_eff = (ha_q == 11'd0) ? 11'd1 : ha_q;

	always_comb begin
		in_ctx.ch = s_axis_tuser[0];
		in_ctx.first = s_axis_tuser[1];
		in_ctx.bin = s_axis_tdata[9:0];
		in_ctx.ok = (13'(s_axis_tdata[9:0]) <= 13'(FFT_SIZE / 2)) &&
		            (4'(s_axis_tuser[0]) < 4'(CHANNELS));
	end

	pvbp_cordic_vec u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (s_axis_tvalid),
		.in_ctx    (in_ctx),
		.in_re     (s_axis_tdata[41:10]),
		.in_im     (s_axis_tdata[73:42]),
		.out_valid (vv),
		.out_ctx   (vctx),
		.out_ang   (vang),
		.out_mag   (vmag)
	);

	assign ang_rnd = vang + PH_RND;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			div_v[0] <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= vv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			div_v[0] <= v_s4;
			v_s6 <= div_v[DW];
			v_s7 <= v_s6;
		end
	end

	assign num_abs = num_s4[DW-1] ? DW'(-num_s4) : DW'(num_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: phase rounding, RAM index, hop products
			it_s1.ctx <= vctx;
			it_s1.idx <= vctx.ch ? IW'(BPC) + IW'(vctx.bin) : IW'(vctx.bin);
			it_s1.phase <= ang_rnd[31 -: PB];
			it_s1.adv_s <= '0;
			it_s1.mag <= vmag;
			prod_a_s1 <= vctx.bin * ha_eff;
			prod_s_s1 <= vctx.bin * hs_q;

			// s2: previous phase read and replaced in one edge
			it_s2 <= '{ctx: it_s1.ctx, idx: it_s1.idx, phase: it_s1.phase,
			           adv_s: PB'(64'(prod_s_s1) << ADV_SH), mag: it_s1.mag};
			adv_a_s2 <= PB'(64'(prod_a_s1) << ADV_SH);
			prev_s2 <= prev_mem[it_s1.idx];
			if (v_s1 && it_s1.ctx.ok) begin
				prev_mem[it_s1.idx] <= it_s1.phase;
			end

			// s3: deviation from the expected advance, wraps to a half turn
			it_s3 <= it_s2;
			d_s3 <= it_s2.phase - prev_s2 - adv_a_s2;

			// s4: scale by the synthesis hop
			it_s4 <= it_s3;
			num_s4 <= $signed(d_s3) * $signed({1'b0, hs_q});

			// divider entry: |num| + Ha/2, sign kept aside
			div_it[0] <= it_s4;
			div_work[0] <= num_abs + DW'(ha_eff[10:1]);
			div_rem[0] <= '0;
			div_neg[0] <= num_s4[DW-1];
		end
	end

	// restoring divide by Ha, one quotient bit per stage
	for (genvar k = 0; k < DW; k++) begin : g_div
		logic [11:0] r2;
		logic        ge;

		assign r2 = {div_rem[k], div_work[k][DW-1]};
		assign ge = r2 >= {1'b0, ha_eff};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v[k+1] <= 1'b0;
			end else if (adv) begin
				div_v[k+1] <= div_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_it[k+1] <= div_it[k];
				div_neg[k+1] <= div_neg[k];
				div_rem[k+1] <= ge ? 11'(r2 - {1'b0, ha_eff}) : 11'(r2);
				div_work[k+1] <= {div_work[k][DW-2:0], ge};
			end
		end
	end

	assign q = div_work[DW][PB-1:0];

	// accumulate: read in s6, add and write back in s7
	assign acc_new = it_s7.ctx.first ? it_s7.phase :
	                 (fwd_s7 ? fwdv_s7 : rd_s7) + inc_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s6 <= div_it[DW];
			inc_s6 <= div_it[DW].adv_s + (div_neg[DW] ? -q : q);

			it_s7 <= it_s6;
			inc_s7 <= inc_s6;
			rd_s7 <= acc_mem[it_s6.idx];
			// entry written at this edge by the item ahead
			fwd_s7 <= v_s7 && it_s7.ctx.ok && (it_s7.idx == it_s6.idx);
			fwdv_s7 <= acc_new;
			if (v_s7 && it_s7.ctx.ok) begin
				acc_mem[it_s7.idx] <= acc_new;
			end
		end
	end

	assign rot_v = v_s7;
	assign rot_ctx = it_s7.ctx;
	assign rot_mag = it_s7.ctx.ok ? it_s7.mag : '0;

	pvbp_cordic_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (rot_v),
		.in_ctx    (rot_ctx),
		.in_mag    (rot_mag),
		.in_ang    (32'(64'(acc_new) << PS)),
		.out_valid (m_axis_tvalid),
		.out_ctx   (m_axis_ctx),
		.out_re    (out_re),
		.out_im    (out_im)
	);

	assign m_axis_tdata = {6'b0, out_im, out_re, m_axis_ctx.bin};
	assign m_axis_tuser = m_axis_ctx.ch;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s4, div_v, v_s7}))
		else $error("pipeline moved during a stall");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (v_s2 == $past(v_s1)) && (v_s7 == $past(v_s6)))
		else $error("valid bit lost or created between stages");

endmodule

`default_nettype wire

FILE: tb/sv/tb_phase_vocoder_bin_propagation.sv
`timescale 1ns / 1ps

module tb_phase_vocoder_bin_propagation;
	import pvbp_pkg::*;

	localparam int BINS = 513;
	localparam int NENT = 2 * BINS;
	localparam logic [23:0] PMASK = 24'hFFFFFF;

	typedef longint unsigned u64_t;

	typedef struct {
		logic        ch;
		logic [9:0]  bin;
		logic        first;
		logic [31:0] re;
		logic [31:0] im;
	} bin_req_t;

	typedef struct {
		logic        ch;
		logic [9:0]  bin;
		logic [31:0] re;
		logic [31:0] im;
	} bin_res_t;

	class resynth_scoreboard;
		bin_res_t    pending[$];
		logic [23:0] prev_ph[NENT];
		logic [23:0] acc_ph[NENT];
		longint unsigned ha_reg, hs_reg;
		int          errors;

		function new();
			ha_reg = 256;
			hs_reg = 128;
			errors = 0;
		endfunction

		function longint unsigned advance(longint unsigned b, longint unsigned hop);
			return (((b * hop) << 24) + 512) / 1024;
		endfunction

		function logic [31:0] clip(longint v);
			if (v > 64'sd2147483647) return 32'h7FFFFFFF;
			if (v < -64'sd2147483648) return 32'h80000000;
			return v[31:0];
		endfunction

		// vectoring CORDIC: angle in 32-bit turns, gain-corrected magnitude
		function logic [31:0] vectoring(longint xi, longint yi, output longint mag);
			longint x, y, dx, dy;
			logic [31:0] ang;
			x = xi;
			y = yi;
			ang = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				ang = 32'h80000000;
			end
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (y > 0) begin
					x += dx; y -= dy; ang += atan_turn(5'(i));
				end else begin
					x -= dx; y += dy; ang -= atan_turn(5'(i));
				end
			end
			mag = (x * longint'(INV_GAIN) + (64'sd1 << 29)) >>> 30;
			return ang;
		endfunction

		function void rotating(longint m, logic [31:0] a, output longint ox, output longint oy);
			longint x, y, z, dx, dy;
			logic [31:0] s;
			x = (m * longint'(INV_GAIN) + (64'sd1 << 29)) >>> 30;
			y = 0;
			s = a + 32'h40000000;
			if (s[31]) begin
				x = -x;
				a = a - 32'h80000000;
			end
			z = longint'($signed(a));
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(atan_turn(5'(i)));
				end else begin
					x += dx; y -= dy; z += longint'(atan_turn(5'(i)));
				end
			end
			ox = x;
			oy = y;
		endfunction

		function void note_request(bin_req_t r);
			bin_res_t e;
			longint mag, ox, oy, ds, num, q;
			longint unsigned ha, d;
			logic [31:0] ang;
			logic [23:0] ph;
			int idx;
			e.ch = r.ch;
			e.bin = r.bin;
			e.re = 0;
			e.im = 0;
			if (r.bin <= 512) begin
				idx = r.ch * BINS + r.bin;
				ang = vectoring(longint'($signed(r.re)), longint'($signed(r.im)), mag);
				ang += 32'd128;
				ph = ang[31:8];
				if (r.first) begin
					acc_ph[idx] = ph;
				end else begin
					ha = (ha_reg == 0) ? 1 : ha_reg;
					d = (u64_t'(ph) - prev_ph[idx] - advance(r.bin, ha)) & 64'hFFFFFF;
					ds = longint'(d);
					if (d[23]) ds -= 64'sd1 << 24;
					num = ds * longint'(hs_reg);
					q = longint'(((num < 0 ? -num : num) + ha / 2) / ha);
					if (num < 0) q = -q;
					acc_ph[idx] = (u64_t'(acc_ph[idx]) + advance(r.bin, hs_reg)
						+ u64_t'(q)) & PMASK;
				end
				prev_ph[idx] = ph;
				rotating(mag, {acc_ph[idx], 8'h00}, ox, oy);
				e.re = clip(ox);
				e.im = clip(oy);
			end
			pending.push_back(e);
		endfunction

		function void check_result(bin_res_t a);
			bin_res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing pending: ch %0d bin %0d", a.ch, a.bin);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.ch !== e.ch) begin
				$error("out_channel: expected %0d, got %0d", e.ch, a.ch); errors++;
			end
			if (a.bin !== e.bin) begin
				$error("out_bin: expected %0d, got %0d", e.bin, a.bin); errors++;
			end
			if (a.re !== e.re) begin
				$error("out_real: expected %h, got %h", e.re, a.re); errors++;
			end
			if (a.im !== e.im) begin
				$error("out_imag: expected %h, got %h", e.im, a.im); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [79:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_we = 0;
	logic [0:0]  cfg_index = '0;
	logic [10:0] cfg_data = '0;

	resynth_scoreboard sb = new();
	bit written[NENT];
	bit no_idle = 0;
	bit hold_req = 0;
	int stall_cycles = 0;

	always #6 clk = ~clk;

	phase_vocoder_bin_propagation DUT (.*);

	always @(posedge clk) begin
		bin_req_t r;
		bin_res_t a;
		if (s_axis_tvalid && s_axis_tready) begin
			r.ch = s_axis_tuser[0];
			r.first = s_axis_tuser[1];
			r.bin = s_axis_tdata[9:0];
			r.re = s_axis_tdata[41:10];
			r.im = s_axis_tdata[73:42];
			sb.note_request(r);
		end
		if (m_axis_tvalid && m_axis_tready) begin
			a.ch = m_axis_tuser[0];
			a.bin = m_axis_tdata[9:0];
			a.re = m_axis_tdata[41:10];
			a.im = m_axis_tdata[73:42];
			sb.check_result(a);
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (sb.pending.size() == 0 && !s_axis_tvalid))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= 3000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// receiver: random backpressure, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else begin
				m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	task automatic send_bin(logic ch, logic [9:0] bin, logic first, logic [31:0] re,
		logic [31:0] im);
		if (!no_idle && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
			repeat ($urandom_range(0, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'd0, im, re, bin};
		s_axis_tuser <= {first, ch};
		if (bin <= 512 && first) written[ch * BINS + bin] = 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		@(posedge clk);
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	task automatic write_hops(logic [10:0] ha, logic [10:0] hs);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= REG_ANALYSIS_HOP;
		cfg_data <= ha;
		@(posedge clk);
		cfg_index <= REG_SYNTHESIS_HOP;
		cfg_data <= hs;
		@(posedge clk);
		cfg_we <= 0;
		sb.ha_reg = ha;
		sb.hs_reg = hs;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h80000000;
			1: return 32'h7FFFFFFF;
			2: return $urandom_range(0, 2000) - 1000;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_bins(int n);
		logic ch;
		logic [9:0] b;
		logic first;
		for (int i = 0; i < n; i++) begin
			ch = 1'($urandom_range(0, 1));
			first = 0;
			if ($urandom_range(0, 99) < 8) begin
				b = 10'($urandom_range(513, 1023));
				first = 1'($urandom_range(0, 1));
			end else begin
				// small bin pool so most bins see continuing frames
				b = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 512))
					: 10'($urandom_range(0, 15));
				if ($urandom_range(0, 99) < 15 || !written[ch * BINS + b]) first = 1;
			end
			send_bin(ch, b, first, rand_sample(), rand_sample());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: edge bins, extreme and zero samples, out-of-range bins
		send_bin(0, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_bin(0, 0, 0, 32'h80000000, 32'h80000000);
		send_bin(1, 512, 1, 32'h80000000, 32'h0);
		send_bin(1, 512, 0, 32'h0, 32'h0);
		send_bin(1, 512, 0, 32'h00010000, 32'h80000000);
		send_bin(0, 1, 1, 0, 0);
		send_bin(0, 1, 0, 32'hFFFF0000, 32'h7FFFFFFF);
		send_bin(0, 1023, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_bin(1, 513, 0, 32'h80000000, 32'h7FFFFFFF);
		send_bin(1, 341, 1, 32'hFFFFFFFF, 32'h00000001);
		send_bin(1, 341, 0, 32'h00000001, 32'hFFFFFFFF);
		send_bin(0, 682, 0, 32'h12345678, 32'h9ABCDEF0);
		drain();

		write_hops(11'd1, 11'd1024);
		send_bin(0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
		send_bin(1, 512, 0, 32'h00400000, 32'h00400000);
		random_bins(150);
		drain();

		// zero analysis hop acts as one; hops above 1024 used as given
		write_hops(11'd0, 11'd2047);
		send_bin(0, 1, 0, 32'h00010000, 32'h00010000);
		random_bins(150);
		drain();

		write_hops(11'd2047, 11'd0);
		random_bins(150);
		hold_req = 1;
		random_bins(100);
		drain();

		write_hops(11'd256, 11'd128);
		no_idle = 1;
		random_bins(150);
		no_idle = 0;
		random_bins(50);
		drain();

		write_hops(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)));
		random_bins(100);
		drain();

		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/pvbp_pkg.sv
rtl/pvbp_cordic_vec.sv
rtl/pvbp_cordic_rot.sv
rtl/phase_vocoder_bin_propagation.sv
tb/sv/tb_phase_vocoder_bin_propagation.sv
